// ===== hdl/pair_comembership_counter_unit_macros.svh =====
// Assertion macros shared by the pair counter RTL.
// Every macro expects clk and rst_n in scope.
`ifndef PAIR_COMEMBERSHIP_COUNTER_UNIT_MACROS_SVH
`define PAIR_COMEMBERSHIP_COUNTER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define PCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcc assertion failed");

// next-cycle implication
`define PCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcc assertion failed");

`else

`define PCC_ASSERT_IMP(lbl, ante, cons)
`define PCC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/pcc_pkg.sv =====
package pcc_pkg;

  // field widths fixed by the interface
  localparam int LABEL_W = 16;
  localparam int OUT_W   = 19;
  localparam int TALLY_W = 20;

  // tallies saturate at all ones in the result width
  localparam logic [TALLY_W-1:0] TALLY_MAX = TALLY_W'(20'h7FFFF);

  typedef struct packed {
    logic [LABEL_W-1:0] label_first;
    logic [LABEL_W-1:0] label_second;
    logic               last_item;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] count_both;
    logic [OUT_W-1:0] count_first_only;
    logic [OUT_W-1:0] count_second_only;
    logic [OUT_W-1:0] count_neither;
    logic             overflowed;
  } out_item_t;

  // control bits that ride along with an item through the cell chain
  typedef struct packed {
    logic valid;   // slot holds an item
    logic active;  // item fits in capacity: compare and store
    logic placed;  // item already stored in some cell
    logic last;    // final item of the set: clears cells as it passes
    logic ovf;     // set overflowed up to and including this item
  } pkt_ctl_t;

endpackage

// ===== hdl/pcc_cell.sv =====
`include "pair_comembership_counter_unit_macros.svh"

module pcc_cell #(
  parameter int CMP_W = 16,
  parameter int CNT_W = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  pcc_pkg::pkt_ctl_t  ctl_i,
  input  logic [CMP_W-1:0]   a_i,
  input  logic [CMP_W-1:0]   b_i,
  input  logic [CNT_W-1:0]   cnt_both_i,
  input  logic [CNT_W-1:0]   cnt_first_i,
  input  logic [CNT_W-1:0]   cnt_second_i,
  input  logic [CNT_W-1:0]   cnt_neither_i,
  output pcc_pkg::pkt_ctl_t  ctl_o,
  output logic [CMP_W-1:0]   a_o,
  output logic [CMP_W-1:0]   b_o,
  output logic [CNT_W-1:0]   cnt_both_o,
  output logic [CNT_W-1:0]   cnt_first_o,
  output logic [CNT_W-1:0]   cnt_second_o,
  output logic [CNT_W-1:0]   cnt_neither_o
);
  import pcc_pkg::*;

  // held observation
  logic             valid_r, valid_nxt;
  logic [CMP_W-1:0] sa_r, sa_nxt;
  logic [CMP_W-1:0] sb_r, sb_nxt;

  // item slot handed to the next cell
  pkt_ctl_t         ctl_r, ctl_nxt;
  logic [CMP_W-1:0] pa_r, pb_r;
  logic [CNT_W-1:0] cb_r, cb_nxt;
  logic [CNT_W-1:0] cf_r, cf_nxt;
  logic [CNT_W-1:0] cs_r, cs_nxt;
  logic [CNT_W-1:0] cn_r, cn_nxt;

  logic hit, store, clr, s1, s2;

  // compare, store into an empty cell, clear behind the last item
  always_comb begin
    s1    = (sa_r == a_i);
    s2    = (sb_r == b_i);
    hit   = ctl_i.valid && ctl_i.active && valid_r;
    store = ctl_i.valid && ctl_i.active && !ctl_i.last && !ctl_i.placed && !valid_r;
    clr   = ctl_i.valid && ctl_i.last;

    cb_nxt = cnt_both_i;
    cf_nxt = cnt_first_i;
    cs_nxt = cnt_second_i;
    cn_nxt = cnt_neither_i;
    if (hit) begin
      if (s1 && s2)  cb_nxt = cnt_both_i + CNT_W'(1);
      else if (s1)   cf_nxt = cnt_first_i + CNT_W'(1);
      else if (s2)   cs_nxt = cnt_second_i + CNT_W'(1);
      else           cn_nxt = cnt_neither_i + CNT_W'(1);
    end

    valid_nxt = valid_r;
    sa_nxt    = sa_r;
    sb_nxt    = sb_r;
    if (clr) begin
      valid_nxt = 1'b0;
    end else if (store) begin
      valid_nxt = 1'b1;
      sa_nxt    = a_i;
      sb_nxt    = b_i;
    end

    ctl_nxt        = ctl_i;
    ctl_nxt.placed = ctl_i.placed || store;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ctl_r   <= '0;
    end else if (en) begin
      valid_r <= valid_nxt;
      ctl_r   <= ctl_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      sa_r <= sa_nxt;
      sb_r <= sb_nxt;
      pa_r <= a_i;
      pb_r <= b_i;
      cb_r <= cb_nxt;
      cf_r <= cf_nxt;
      cs_r <= cs_nxt;
      cn_r <= cn_nxt;
    end
  end

  assign ctl_o         = ctl_r;
  assign a_o           = pa_r;
  assign b_o           = pb_r;
  assign cnt_both_o    = cb_r;
  assign cnt_first_o   = cf_r;
  assign cnt_second_o  = cs_r;
  assign cnt_neither_o = cn_r;

  // the last item of a set empties every cell it passes
  `PCC_ASSERT_NXT(a_cell_clear, en && ctl_i.valid && ctl_i.last, !valid_r)
  // a held observation is never overwritten
  `PCC_ASSERT_NXT(a_cell_hold, valid_r && !(en && ctl_i.valid && ctl_i.last), valid_r && $stable(sa_r) && $stable(sb_r))

endmodule

// ===== hdl/pcc_tally.sv =====
`include "pair_comembership_counter_unit_macros.svh"

module pcc_tally #(
  parameter int CNT_W = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  pcc_pkg::pkt_ctl_t  ctl_i,
  input  logic [CNT_W-1:0]   cnt_both_i,
  input  logic [CNT_W-1:0]   cnt_first_i,
  input  logic [CNT_W-1:0]   cnt_second_i,
  input  logic [CNT_W-1:0]   cnt_neither_i,
  input  logic               out_stall,
  output logic               out_valid,
  output pcc_pkg::out_item_t out_item
);
  import pcc_pkg::*;

  logic [TALLY_W-1:0] tally_both_r, tally_both_nxt;
  logic [TALLY_W-1:0] tally_first_r, tally_first_nxt;
  logic [TALLY_W-1:0] tally_second_r, tally_second_nxt;
  logic [TALLY_W-1:0] tally_neither_r, tally_neither_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic [TALLY_W-1:0] sat_both, sat_first, sat_second, sat_neither;
  logic               emit;

  function automatic logic [TALLY_W-1:0] sat_add(input logic [TALLY_W-1:0] t,
                                                 input logic [CNT_W-1:0]   c);
    logic [TALLY_W-1:0] s;
    s = t + TALLY_W'(c);
    return (s > TALLY_MAX) ? TALLY_MAX : s;
  endfunction

  // fold each finished item's counts into the set tallies; a set's last item emits and clears them
  always_comb begin
    sat_both    = sat_add(tally_both_r, cnt_both_i);
    sat_first   = sat_add(tally_first_r, cnt_first_i);
    sat_second  = sat_add(tally_second_r, cnt_second_i);
    sat_neither = sat_add(tally_neither_r, cnt_neither_i);
    emit        = adv && ctl_i.valid && ctl_i.last;

    tally_both_nxt    = tally_both_r;
    tally_first_nxt   = tally_first_r;
    tally_second_nxt  = tally_second_r;
    tally_neither_nxt = tally_neither_r;
    if (adv && ctl_i.valid) begin
      if (ctl_i.last) begin
        tally_both_nxt    = '0;
        tally_first_nxt   = '0;
        tally_second_nxt  = '0;
        tally_neither_nxt = '0;
      end else begin
        tally_both_nxt    = sat_both;
        tally_first_nxt   = sat_first;
        tally_second_nxt  = sat_second;
        tally_neither_nxt = sat_neither;
      end
    end
  end

  // result register
  always_comb begin
    out_item_nxt = out_item_r;
    if (emit) begin
      out_item_nxt.count_both        = sat_both[OUT_W-1:0];
      out_item_nxt.count_first_only  = sat_first[OUT_W-1:0];
      out_item_nxt.count_second_only = sat_second[OUT_W-1:0];
      out_item_nxt.count_neither     = sat_neither[OUT_W-1:0];
      out_item_nxt.overflowed        = ctl_i.ovf;
    end
    if (emit)           out_valid_nxt = 1'b1;
    else if (out_stall) out_valid_nxt = out_valid_r;
    else                out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_both_r    <= '0;
      tally_first_r   <= '0;
      tally_second_r  <= '0;
      tally_neither_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      tally_both_r    <= tally_both_nxt;
      tally_first_r   <= tally_first_nxt;
      tally_second_r  <= tally_second_nxt;
      tally_neither_r <= tally_neither_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // emitting a result starts the next set from zero
  `PCC_ASSERT_NXT(a_tally_emit, emit, out_valid_r && tally_both_r == '0 && tally_first_r == '0 && tally_second_r == '0 && tally_neither_r == '0)
  // tallies hold while the chain is held
  `PCC_ASSERT_NXT(a_tally_hold, !adv, $stable(tally_both_r) && $stable(tally_first_r) && $stable(tally_second_r) && $stable(tally_neither_r))

endmodule

// ===== hdl/pair_comembership_counter_unit.sv =====
// Each item walks the chain of MAX_ITEMS cells; the last item of a set then reaches the
// tally, whose result register raises out_valid. One item per cycle while in_stall is low.
// The whole chain holds while a result waits under out_stall, so in_stall follows it.
// Reset (synchronous, rst_n low) clears cell valid bits, the item count, overflow flag,
// tallies and the result valid; held labels are not reset.
`include "pair_comembership_counter_unit_macros.svh"

module pair_comembership_counter_unit #(
  parameter int MAX_ITEMS  = 1024,
  parameter int LABEL_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pcc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output pcc_pkg::out_item_t out_item
);
  import pcc_pkg::*;

  localparam int CMP_W  = (LABEL_BITS < LABEL_W) ? LABEL_BITS : LABEL_W;
  localparam int CNT_W  = $clog2(MAX_ITEMS);
  localparam int CNTR_W = $clog2(MAX_ITEMS + 1);

  logic              adv, accept, full;
  logic [CNTR_W-1:0] item_cnt_r, item_cnt_nxt;
  logic              ovf_r, ovf_nxt;

  pkt_ctl_t          ctl_w  [MAX_ITEMS+1];
  logic [CMP_W-1:0]  a_w    [MAX_ITEMS+1];
  logic [CMP_W-1:0]  b_w    [MAX_ITEMS+1];
  logic [CNT_W-1:0]  cb_w   [MAX_ITEMS+1];
  logic [CNT_W-1:0]  cf_w   [MAX_ITEMS+1];
  logic [CNT_W-1:0]  cs_w   [MAX_ITEMS+1];
  logic [CNT_W-1:0]  cn_w   [MAX_ITEMS+1];

  // the chain moves unless a result is waiting and stalled
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign full     = (item_cnt_r == CNTR_W'(MAX_ITEMS));

  // per-set item count and overflow flag
  always_comb begin
    item_cnt_nxt = item_cnt_r;
    ovf_nxt      = ovf_r;
    if (accept) begin
      if (in_item.last_item) begin
        item_cnt_nxt = '0;
        ovf_nxt      = 1'b0;
      end else begin
        if (!full) item_cnt_nxt = item_cnt_r + CNTR_W'(1);
        ovf_nxt = ovf_r || full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_cnt_r <= '0;
      ovf_r      <= 1'b0;
    end else begin
      item_cnt_r <= item_cnt_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  // chain entry: a bubble when nothing is accepted
  always_comb begin
    ctl_w[0].valid  = accept;
    ctl_w[0].active = !full;
    ctl_w[0].placed = 1'b0;
    ctl_w[0].last   = in_item.last_item;
    ctl_w[0].ovf    = ovf_r || full;
    a_w[0]  = in_item.label_first[CMP_W-1:0];
    b_w[0]  = in_item.label_second[CMP_W-1:0];
    cb_w[0] = '0;
    cf_w[0] = '0;
    cs_w[0] = '0;
    cn_w[0] = '0;
  end

  // one cell per storable observation
  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    pcc_cell #(
      .CMP_W(CMP_W),
      .CNT_W(CNT_W)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .en            (adv),
      .ctl_i         (ctl_w[k]),
      .a_i           (a_w[k]),
      .b_i           (b_w[k]),
      .cnt_both_i    (cb_w[k]),
      .cnt_first_i   (cf_w[k]),
      .cnt_second_i  (cs_w[k]),
      .cnt_neither_i (cn_w[k]),
      .ctl_o         (ctl_w[k+1]),
      .a_o           (a_w[k+1]),
      .b_o           (b_w[k+1]),
      .cnt_both_o    (cb_w[k+1]),
      .cnt_first_o   (cf_w[k+1]),
      .cnt_second_o  (cs_w[k+1]),
      .cnt_neither_o (cn_w[k+1])
    );
  end

  // end of chain: accumulate and emit
  pcc_tally #(
    .CNT_W(CNT_W)
  ) u_tally (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .ctl_i         (ctl_w[MAX_ITEMS]),
    .cnt_both_i    (cb_w[MAX_ITEMS]),
    .cnt_first_i   (cf_w[MAX_ITEMS]),
    .cnt_second_i  (cs_w[MAX_ITEMS]),
    .cnt_neither_i (cn_w[MAX_ITEMS]),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_item      (out_item)
  );

  // a set closes with a clean count and flag
  `PCC_ASSERT_NXT(a_set_close, accept && in_item.last_item, item_cnt_r == CNTR_W'(0) && !ovf_r)

endmodule

// ===== verif/pair_comembership_counter_checker.sv =====
module pair_comembership_counter_checker #(
  parameter int MAX_ITEMS  = 1024,
  parameter int LABEL_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  pcc_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  pcc_pkg::out_item_t out_item,
  output int                 mismatch_count,
  output int                 pending_results
);
  import pcc_pkg::*;

  localparam logic [LABEL_W-1:0] LABEL_MASK = LABEL_W'((64'd1 << LABEL_BITS) - 64'd1);
  localparam int IDX_W = $clog2(MAX_ITEMS);

  // labels of the current set, in arrival order
  logic [LABEL_W-1:0] held_first  [MAX_ITEMS];
  logic [LABEL_W-1:0] held_second [MAX_ITEMS];
  int                 held_count;

  logic [TALLY_W-1:0] pairs_both;
  logic [TALLY_W-1:0] pairs_first_only;
  logic [TALLY_W-1:0] pairs_second_only;
  logic [TALLY_W-1:0] pairs_neither;
  logic               set_overflowed;

  // tallies of finished sets, oldest first
  out_item_t expected_tallies [$];

  function automatic logic [TALLY_W-1:0] saturating_inc(input logic [TALLY_W-1:0] t);
    return (t < TALLY_MAX) ? t + TALLY_W'(1) : t;
  endfunction

  task automatic clear_set();
    held_count        = 0;
    pairs_both        = '0;
    pairs_first_only  = '0;
    pairs_second_only = '0;
    pairs_neither     = '0;
    set_overflowed    = 1'b0;
  endtask

  // pair the new item with every held one, then store it (or flag it beyond capacity)
  task automatic absorb_item(input in_item_t it);
    logic [LABEL_W-1:0] a;
    logic [LABEL_W-1:0] b;
    logic               same_first;
    logic               same_second;
    out_item_t          tallies;
    a = it.label_first & LABEL_MASK;
    b = it.label_second & LABEL_MASK;
    if (held_count < MAX_ITEMS) begin
      for (int k = 0; k < held_count; k++) begin
        same_first  = (held_first[IDX_W'(k)] == a);
        same_second = (held_second[IDX_W'(k)] == b);
        if (same_first && same_second) begin
          pairs_both = saturating_inc(pairs_both);
        end else if (same_first) begin
          pairs_first_only = saturating_inc(pairs_first_only);
        end else if (same_second) begin
          pairs_second_only = saturating_inc(pairs_second_only);
        end else begin
          pairs_neither = saturating_inc(pairs_neither);
        end
      end
      held_first[IDX_W'(held_count)]  = a;
      held_second[IDX_W'(held_count)] = b;
      held_count++;
    end else begin
      // beyond capacity: dropped, only flagged
      set_overflowed = 1'b1;
    end
    if (it.last_item) begin
      tallies.count_both        = pairs_both[OUT_W-1:0];
      tallies.count_first_only  = pairs_first_only[OUT_W-1:0];
      tallies.count_second_only = pairs_second_only[OUT_W-1:0];
      tallies.count_neither     = pairs_neither[OUT_W-1:0];
      tallies.overflowed        = set_overflowed;
      expected_tallies.push_back(tallies);
      clear_set();
    end
  endtask

  function automatic bit field_differs(input string name, input logic [OUT_W-1:0] want,
                                       input logic [OUT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_tallies.size() == 0) begin
      $display("%0t: result with nothing expected: both %0d first_only %0d second_only %0d",
               $time, got.count_both, got.count_first_only, got.count_second_only);
      $display("%0t:   neither %0d overflowed %0d", $time, got.count_neither, got.overflowed);
      mismatch_count++;
    end else begin
      want = expected_tallies.pop_front();
      if (field_differs("count_both", want.count_both, got.count_both) |
          field_differs("count_first_only", want.count_first_only, got.count_first_only) |
          field_differs("count_second_only", want.count_second_only, got.count_second_only) |
          field_differs("count_neither", want.count_neither, got.count_neither) |
          field_differs("overflowed", OUT_W'(want.overflowed), OUT_W'(got.overflowed))) begin
        mismatch_count++;
      end
    end
  endtask

  // watch both channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_set();
      expected_tallies.delete();
      mismatch_count  = 0;
      pending_results = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_item);
      end
      if (in_valid && !in_stall) begin
        absorb_item(in_item);
      end
      pending_results = expected_tallies.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import pcc_pkg::*;

  localparam int CAPACITY        = 1024;
  localparam int LABEL_BITS      = 16;
  localparam int DRAIN_CYCLES    = CAPACITY + 64;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int PHASE_ITEMS     = 150;
  localparam int CYCLE_LIMIT     = 400000;

  typedef enum int {
    FLOW_FREE,
    FLOW_SENDER_IDLE,
    FLOW_RECEIVER_STALL,
    FLOW_BOTH,
    FLOW_PRESSURE
  } flow_mode_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_item;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_item;
  int         mismatch_count;
  int         pending_results;
  flow_mode_t flow;
  logic       holding_off;
  int         cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pair_comembership_counter_unit #(
    .MAX_ITEMS  (CAPACITY),
    .LABEL_BITS (LABEL_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  pair_comembership_counter_checker #(
    .MAX_ITEMS  (CAPACITY),
    .LABEL_BITS (LABEL_BITS)
  ) tally_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  function automatic bit roll(input int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // percent of cycles one side sits out in each flow mode
  function automatic int idle_pct(input flow_mode_t f, input bit sender_side);
    case (f)
      FLOW_SENDER_IDLE:    return sender_side ? 80 : 0;
      FLOW_RECEIVER_STALL: return sender_side ? 0 : 80;
      FLOW_BOTH:           return 38;
      default:             return 0;
    endcase
  endfunction

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on entering pressure mode
  initial begin : receiver
    int         hold_left;
    flow_mode_t seen_flow;
    hold_left   = 0;
    seen_flow   = FLOW_FREE;
    out_stall   = 1'b0;
    holding_off = 1'b0;
    forever begin
      @(negedge clk);
      if (flow == FLOW_PRESSURE && seen_flow != FLOW_PRESSURE) begin
        hold_left = HOLD_OFF_CYCLES;
      end
      seen_flow = flow;
      if (hold_left > 0) begin
        hold_left--;
        out_stall   <= 1'b1;
        holding_off <= 1'b1;
      end else begin
        out_stall   <= roll(idle_pct(flow, 1'b0));
        holding_off <= 1'b0;
      end
    end
  end

  // offer one item; entered and left at a falling edge
  task automatic drive_item(input in_item_t it);
    while (roll(idle_pct(flow, 1'b1))) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // one set drawn from small label pools so that matches are common
  task automatic send_random_set(inout int item_total);
    int                 set_size;
    int                 first_n;
    int                 second_n;
    logic [LABEL_W-1:0] pool_first [4];
    logic [LABEL_W-1:0] pool_second [4];
    in_item_t           it;
    set_size = roll(90) ? $urandom_range(12, 1) : $urandom_range(80, 13);
    first_n  = $urandom_range(4, 1);
    second_n = $urandom_range(4, 1);
    for (int p = 0; p < 4; p++) begin
      pool_first[p]  = roll(20) ? (roll(50) ? '1 : '0) : LABEL_W'($urandom);
      pool_second[p] = roll(20) ? (roll(50) ? '1 : '0) : LABEL_W'($urandom);
    end
    for (int i = 0; i < set_size; i++) begin
      it.label_first  = roll(85) ? pool_first[2'($urandom_range(first_n - 1, 0))]
                                 : LABEL_W'($urandom);
      it.label_second = roll(85) ? pool_second[2'($urandom_range(second_n - 1, 0))]
                                 : LABEL_W'($urandom);
      it.last_item    = (i == set_size - 1);
      drive_item(it);
    end
    item_total += set_size;
  endtask

  initial begin : stimulus
    int       item_total;
    in_item_t it;
    item_total = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    flow       = FLOW_FREE;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // set of one item: all counts zero
    drive_item(in_item_t'{16'h0000, 16'h0000, 1'b1});
    // two identical all-ones items: one pair in both
    drive_item(in_item_t'{16'hFFFF, 16'hFFFF, 1'b0});
    drive_item(in_item_t'{16'hFFFF, 16'hFFFF, 1'b1});
    // first-only, second-only and neither pairs inside one set
    drive_item(in_item_t'{16'h0000, 16'h0000, 1'b0});
    drive_item(in_item_t'{16'h0000, 16'hFFFF, 1'b0});
    drive_item(in_item_t'{16'hFFFF, 16'h0000, 1'b0});
    drive_item(in_item_t'{16'hFFFF, 16'hFFFF, 1'b0});
    drive_item(in_item_t'{16'h5555, 16'hAAAA, 1'b0});
    drive_item(in_item_t'{16'hAAAA, 16'h5555, 1'b0});
    drive_item(in_item_t'{16'h5555, 16'h5555, 1'b1});
    // labels that differ only in the top or bottom bit
    drive_item(in_item_t'{16'h8000, 16'h0001, 1'b0});
    drive_item(in_item_t'{16'h0000, 16'h0001, 1'b0});
    drive_item(in_item_t'{16'h8000, 16'h0000, 1'b1});

    // exactly at capacity, all labels equal: largest possible count
    for (int i = 0; i < CAPACITY; i++) begin
      drive_item(in_item_t'{16'hFFFF, 16'hFFFF, i == CAPACITY - 1});
    end
    // beyond capacity: the last two items are dropped, the last still closes the set
    for (int i = 0; i < CAPACITY + 2; i++) begin
      it.label_first  = roll(50) ? 16'hFFFF : 16'h0000;
      it.label_second = roll(50) ? 16'hFFFF : 16'h0000;
      it.last_item    = (i == CAPACITY + 1);
      drive_item(it);
    end

    // random sets under each flow mode from FLOW_FREE to FLOW_BOTH
    for (int m = FLOW_FREE; m <= FLOW_BOTH; m++) begin
      flow <= flow_mode_t'(m);
      while (item_total < (m + 1) * PHASE_ITEMS) send_random_set(item_total);
    end
    // keep offering through the long hold-off so the chain backs up into the input
    flow     <= FLOW_PRESSURE;
    in_valid <= 1'b0;
    do @(negedge clk); while (!holding_off);
    while (holding_off) send_random_set(item_total);
    flow <= FLOW_BOTH;
    while (item_total < 800) send_random_set(item_total);

    in_valid <= 1'b0;
    flow     <= FLOW_FREE;
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
